// ----- rtl/core/ips_pkg.sv -----
package ips_pkg;

  // Field widths of the item and result words.
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 3;
  localparam int OCC_W  = 16;
  localparam int KEY_W  = 8;
  localparam int MODE_W = 2;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_PLACEMENT_MODE = 3'd0;

  // Default table depth.
  localparam int INSTANCE_SLOTS_DEFAULT = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CONNECT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CHOOSE     = 2'd3;

  // Placement modes.
  localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAST_USED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY_RANGE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNDEFINED   = 2'd3;

  // Letters 'a' through 'z'.
  localparam int LETTER_FIRST = 97;

  localparam int BLOCK_W = 5;

  // Letters per block, ceil(26 / q), for q connected instances.
  function automatic logic [BLOCK_W-1:0] block_size(input logic [5:0] q);
    logic [BLOCK_W-1:0] b;
    case (q) inside
      6'd1:            b = 5'd26;
      6'd2:            b = 5'd13;
      6'd3:            b = 5'd9;
      6'd4:            b = 5'd7;
      6'd5:            b = 5'd6;
      6'd6:            b = 5'd5;
      [6'd7:6'd8]:     b = 5'd4;
      [6'd9:6'd12]:    b = 5'd3;
      [6'd13:6'd25]:   b = 5'd2;
      default:         b = 5'd1;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/ips_item_if.sv -----
interface ips_item_if;
  logic                         valid;
  logic                         ready;
  logic [ips_pkg::CMD_W-1:0]    command;
  logic [ips_pkg::SLOT_W-1:0]   slot;
  logic [ips_pkg::OCC_W-1:0]    occupancy;
  logic [ips_pkg::KEY_W-1:0]    key_first_byte;
  logic                         simulate;

  modport source (output valid, command, slot, occupancy, key_first_byte, simulate,
                  input ready);
  modport sink (input valid, command, slot, occupancy, key_first_byte, simulate,
                output ready);
endinterface

// ----- rtl/core/ips_result_if.sv -----
interface ips_result_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [ips_pkg::SLOT_W-1:0]   chosen_slot;

  modport source (output valid, status, chosen_slot, input ready);
  modport sink (input valid, status, chosen_slot, output ready);
endinterface

// ----- rtl/core/instance_placement_selector_top.sv -----
// Table commands (connect, disconnect, update) pass their result word to the pending register,
// then to the output register. A placement request scans the occupancy memory one slot per cycle
// through its single read port. No new item is taken while a scan runs or a word is pending.
// Synchronous reset clears the connected flags, the connected count, the round-robin position
// and the mode; the occupancy memory is not cleared, as a slot is always written when connected.
module instance_placement_selector_top #(
  parameter int INSTANCE_SLOTS = ips_pkg::INSTANCE_SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  ips_item_if.sink                          item,
  ips_result_if.source                      result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ips_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ips_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ips_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int SW = $clog2(INSTANCE_SLOTS);
  localparam int CW = $clog2(INSTANCE_SLOTS + 1);
  localparam int VW = 10;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Configuration register.
  logic [ips_pkg::MODE_W-1:0] mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ips_pkg::MODE_ROUND_ROBIN;
    end else if (psel && penable && pwrite && pready && paddr == ips_pkg::REG_PLACEMENT_MODE) begin
      mode <= pwdata[ips_pkg::MODE_W-1:0];
    end
  end

  assign prdata = (paddr == ips_pkg::REG_PLACEMENT_MODE) ?
                  ips_pkg::APB_DATA_W'(mode) : '0;

  // Control and slot state.
  logic                       state;
  logic [INSTANCE_SLOTS-1:0]  connected;
  logic [CW-1:0]              conn_count;
  logic [CW-1:0]              next_pos;
  logic                       pend_valid;
  logic                       pend_status;
  logic [SW-1:0]              pend_slot;
  logic                       out_valid;
  logic                       out_status;
  logic [ips_pkg::SLOT_W-1:0] out_slot;

  // Per-request scan registers.
  logic [ips_pkg::MODE_W-1:0] scan_mode;
  logic [CW-1:0]              scan_q;
  logic [CW-1:0]              scan_pos;
  logic [ips_pkg::BLOCK_W-1:0] blk;
  logic signed [VW-1:0]       key_v;
  logic signed [VW-1:0]       lo;
  logic [CW-1:0]              issue_cnt;
  logic                       eval_valid;
  logic [SW-1:0]              eval_slot;
  logic [CW-1:0]              rank;
  logic                       found;
  logic [SW-1:0]              pick;
  logic [SW-1:0]              last;
  logic [ips_pkg::OCC_W-1:0]  best_occ;

  // Occupancy memory with a registered read port.
  logic [ips_pkg::OCC_W-1:0]  occ_mem [INSTANCE_SLOTS];
  logic [ips_pkg::OCC_W-1:0]  occ_rd;

  logic accept;
  logic slot_ok;
  logic [SW-1:0] in_slot;
  logic [CW-1:0] start_pos;
  logic choose_ok;

  assign item.ready = (state == ST_IDLE) && !pend_valid;
  assign accept     = item.valid && item.ready;
  assign slot_ok    = 32'(item.slot) < INSTANCE_SLOTS;
  assign in_slot    = SW'(item.slot);
  assign start_pos  = (next_pos >= conn_count) ? '0 : next_pos;
  assign choose_ok  = (conn_count != '0) && (mode != ips_pkg::MODE_UNDEFINED);

  always_ff @(posedge clk) begin
    if (accept && slot_ok &&
        (item.command == ips_pkg::CMD_CONNECT || item.command == ips_pkg::CMD_UPDATE)) begin
      occ_mem[in_slot] <= item.occupancy;
    end
    occ_rd <= occ_mem[issue_cnt[SW-1:0]];
  end

  // One scan step on the slot whose count has just been read.
  logic          flag;
  logic          hit_key;
  logic          found_upd;
  logic [SW-1:0] pick_upd;
  logic [SW-1:0] last_upd;
  logic          finish;

  assign flag = connected[eval_slot];

  always_comb begin
    found_upd = found;
    pick_upd  = pick;
    last_upd  = last;
    hit_key   = ((CW + 1)'(rank) + (CW + 1)'(1) < (CW + 1)'(scan_q)) &&
                (key_v >= lo) && (key_v < lo + $signed(VW'(blk)));
    if (flag) begin
      last_upd = eval_slot;
      case (scan_mode)
        ips_pkg::MODE_ROUND_ROBIN: begin
          if (!found && rank == scan_pos) begin
            found_upd = 1'b1;
            pick_upd  = eval_slot;
          end
        end
        ips_pkg::MODE_LEAST_USED: begin
          if (!found || occ_rd < best_occ) begin
            found_upd = 1'b1;
            pick_upd  = eval_slot;
          end
        end
        ips_pkg::MODE_KEY_RANGE: begin
          if (!found && hit_key) begin
            found_upd = 1'b1;
            pick_upd  = eval_slot;
          end
        end
        default: begin
          found_upd = found;
        end
      endcase
    end
  end

  assign finish = (state == ST_SCAN) && eval_valid && (32'(eval_slot) == INSTANCE_SLOTS - 1);

  // Scan sequencing: issue one read a cycle, evaluate the slot in the cycle after its read.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      if (32'(issue_cnt) < INSTANCE_SLOTS) begin
        issue_cnt  <= issue_cnt + CW'(1);
        eval_valid <= 1'b1;
        eval_slot  <= issue_cnt[SW-1:0];
      end else begin
        eval_valid <= 1'b0;
      end
      if (eval_valid) begin
        found <= found_upd;
        pick  <= pick_upd;
        last  <= last_upd;
        if (flag) begin
          rank <= rank + CW'(1);
          lo   <= lo + $signed(VW'(blk));
          if (pick_upd == eval_slot && found_upd) begin
            best_occ <= occ_rd;
          end
        end
      end
    end else if (accept) begin
      issue_cnt  <= '0;
      eval_valid <= 1'b0;
      eval_slot  <= '0;
      rank       <= '0;
      lo         <= '0;
      found      <= 1'b0;
      pick       <= '0;
      last       <= '0;
      best_occ   <= '0;
      scan_mode  <= mode;
      scan_q     <= conn_count;
      scan_pos   <= start_pos;
      blk        <= ips_pkg::block_size(6'(conn_count));
      key_v      <= $signed({{(VW - ips_pkg::KEY_W){item.key_first_byte[ips_pkg::KEY_W-1]}},
                             item.key_first_byte}) - VW'(ips_pkg::LETTER_FIRST);
    end
  end

  // Control: slot table, round-robin position, pending and output words.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      connected  <= '0;
      conn_count <= '0;
      next_pos   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pend_valid && (!out_valid || result.ready)) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_slot   <= ips_pkg::SLOT_W'(pend_slot);
        pend_valid <= 1'b0;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        case (item.command)
          ips_pkg::CMD_CONNECT: begin
            if (slot_ok) begin
              connected[in_slot] <= 1'b1;
              if (!connected[in_slot]) begin
                conn_count <= conn_count + CW'(1);
              end
            end
            pend_valid  <= 1'b1;
            pend_status <= 1'b0;
            pend_slot   <= '0;
          end
          ips_pkg::CMD_DISCONNECT: begin
            if (slot_ok) begin
              connected[in_slot] <= 1'b0;
              if (connected[in_slot]) begin
                conn_count <= conn_count - CW'(1);
              end
            end
            pend_valid  <= 1'b1;
            pend_status <= 1'b0;
            pend_slot   <= '0;
          end
          ips_pkg::CMD_UPDATE: begin
            pend_valid  <= 1'b1;
            pend_status <= 1'b0;
            pend_slot   <= '0;
          end
          default: begin
            if (choose_ok) begin
              state <= ST_SCAN;
              if (mode == ips_pkg::MODE_ROUND_ROBIN && !item.simulate) begin
                next_pos <= start_pos + CW'(1);
              end
            end else begin
              pend_valid  <= 1'b1;
              pend_status <= 1'b1;
              pend_slot   <= '0;
            end
          end
        endcase
      end

      if (finish) begin
        state       <= ST_IDLE;
        pend_valid  <= 1'b1;
        pend_status <= 1'b0;
        pend_slot   <= found_upd ? pick_upd : last_upd;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.chosen_slot = out_slot;

  // The connected count tracks the flags.
  assert property (@(posedge clk) disable iff (rst)
    conn_count == CW'($countones(connected)))
    else $error("connected count differs from the connected flags");

  // No item is taken while a placement scan runs.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !item.ready)
    else $error("item accepted during a scan");

  // Round robin and least used always land on a connected slot.
  assert property (@(posedge clk) disable iff (rst)
    finish && (scan_mode == ips_pkg::MODE_ROUND_ROBIN ||
               scan_mode == ips_pkg::MODE_LEAST_USED) |-> found_upd)
    else $error("scan ended without a pick");

  // A finished scan hands its word to the pending register.
  assert property (@(posedge clk) disable iff (rst)
    finish |=> pend_valid && !pend_status && state == ST_IDLE)
    else $error("scan result not captured");

endmodule
